// File: sv/head_unit_display_message_parser_macros.svh
// assertion macros for the display message parser checker
`ifndef HEAD_UNIT_DISPLAY_MESSAGE_PARSER_MACROS_SVH
`define HEAD_UNIT_DISPLAY_MESSAGE_PARSER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define HUDMP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hudmp check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define HUDMP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hudmp check failed");

`endif

// File: sv/hudmp_pkg.sv
`default_nettype none

package hudmp_pkg;

    // text store geometry
    localparam int TEXT_DEPTH = 512;
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
    localparam int LEN_W      = $clog2(TEXT_DEPTH + 1);
    localparam int MAIN_DEPTH = 2 * TEXT_DEPTH;
    localparam int MAIN_AW    = TEXT_AW + 1;

    // escape sequence window
    localparam int WIN_N = 14;
    localparam int CTR_N = 8;

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // message bytes
    localparam logic [7:0] HDR_LEAD   = 8'h06;
    localparam logic [7:0] HDR_ID     = 8'hC1;
    localparam logic [7:0] TYPE_MAIN  = 8'hC0;
    localparam logic [7:0] TYPE_POPUP = 8'h40;
    localparam logic [7:0] TYPE_ICON  = 8'h50;
    localparam logic [7:0] SUB_START  = 8'h03;
    localparam logic [7:0] SUB_MAIN   = 8'h10;
    localparam logic [7:0] SUB_POPUP  = 8'h90;
    localparam logic [7:0] REC_MP3    = 8'h80;
    localparam logic [7:0] REC_RDM    = 8'h83;

    localparam logic [7:0] SEQ_CENTER [CTR_N] = '{
        8'h00, 8'h1B, 8'h00, 8'h5B, 8'h00, 8'h63, 8'h00, 8'h6D};
    localparam logic [7:0] SEQ_PSEUDO [WIN_N] = '{
        8'h00, 8'h1B, 8'h00, 8'h5B, 8'h00, 8'h66, 8'h00, 8'h53,
        8'h00, 8'h5F, 8'h00, 8'h64, 8'h00, 8'h6D};
    localparam logic [7:0] SEQ_NORMAL [WIN_N] = '{
        8'h00, 8'h1B, 8'h00, 8'h5B, 8'h00, 8'h66, 8'h00, 8'h53,
        8'h00, 8'h5F, 8'h00, 8'h67, 8'h00, 8'h6D};

    // result kinds
    localparam logic [1:0] EV_ICON    = 2'd0;
    localparam logic [1:0] EV_SUMMARY = 2'd1;
    localparam logic [1:0] EV_READ    = 2'd2;

    // icon ids
    localparam logic [2:0] ID_ALL_OFF = 3'd0;
    localparam logic [2:0] ID_AS      = 3'd1;
    localparam logic [2:0] ID_RDS     = 3'd2;
    localparam logic [2:0] ID_CDIN    = 3'd3;
    localparam logic [2:0] ID_TP      = 3'd4;
    localparam logic [2:0] ID_MP3     = 3'd5;
    localparam logic [2:0] ID_RDM     = 3'd6;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] icon_id;
        logic [1:0] icon_value;
        logic       main_updated;
        logic       popup_shown;
        logic       main_centered;
        logic       popup_centered;
        logic       pseudo_graphics;
        logic [8:0] main_length;
        logic [8:0] popup_length;
        logic [7:0] read_byte;
    } t_res;

    // results of one transaction, registered in the cycle after acceptance
    typedef struct packed {
        logic [1:0] cnt;
        logic       rd;
        logic       rd_popup;
        logic       rd_zero;
        t_res       r0;
        t_res       r1;
    } t_s2;

    // text store access requests
    typedef struct packed {
        logic               main_we;
        logic               pop_we;
        logic [7:0]         wdata;
        logic [MAIN_AW-1:0] main_waddr;
        logic [TEXT_AW-1:0] pop_waddr;
        logic [MAIN_AW-1:0] main_raddr;
        logic [TEXT_AW-1:0] pop_raddr;
    } t_memreq;

endpackage

`default_nettype wire

// File: sv/head_unit_display_message_parser.sv
// throughput: one transaction per cycle while o_ready is high; a result passes the s2 register and the result queue
// at the end of each text section input stalls while the window bytes left (up to 13) are flushed and the length
// is settled, and further while a popup text of the main text's length is compared byte by byte
// the compare pass shares the single read port of each text store
// reset: synchronous active-low, clears parser state, flags, lengths and result queue;
// text stores are not cleared, no clearing pass
`default_nettype none

module head_unit_display_message_parser import hudmp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_byte_value,
    input  logic       i_last,
    input  logic       i_read_popup,
    input  logic [8:0] i_read_index,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_event_res,
    output logic [2:0] o_icon_id,
    output logic [1:0] o_icon_value,
    output logic       o_main_updated,
    output logic       o_popup_shown,
    output logic       o_main_centered,
    output logic       o_popup_centered,
    output logic       o_pseudo_graphics,
    output logic [8:0] o_main_length,
    output logic [8:0] o_popup_length,
    output logic [7:0] o_read_byte
);

    logic               acc;
    logic               busy;
    t_memreq            mem;
    t_s2                s2;
    logic [7:0]         main_rdata;
    logic [7:0]         pop_rdata;
    logic [OUTQ_CW-1:0] q_cnt;
    t_res               head;
    t_res               d0;

    // accept while not busy and the queue, counting results in flight, can take two more results
    assign o_ready = !busy && ((q_cnt + OUTQ_CW'(s2.cnt)) <= OUTQ_CW'(OUTQ_DEPTH - 2));
    assign acc     = i_valid && o_ready;

    hudmp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_kind       (i_kind),
        .i_byte_value (i_byte_value),
        .i_last       (i_last),
        .i_read_popup (i_read_popup),
        .i_read_index (i_read_index),
        .i_main_rdata (main_rdata),
        .i_pop_rdata  (pop_rdata),
        .o_busy       (busy),
        .o_mem        (mem),
        .o_s2         (s2)
    );

    hudmp_ram #(.WIDTH(8), .DEPTH(MAIN_DEPTH)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (mem.main_we),
        .i_waddr (mem.main_waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.main_raddr),
        .o_rdata (main_rdata)
    );

    hudmp_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_pop_ram (
        .i_clk   (i_clk),
        .i_we    (mem.pop_we),
        .i_waddr (mem.pop_waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.pop_raddr),
        .o_rdata (pop_rdata)
    );

    // merge read data into a read result
    always_comb begin
        d0 = s2.r0;
        if (s2.rd) begin
            d0.read_byte = s2.rd_zero ? 8'd0 : (s2.rd_popup ? pop_rdata : main_rdata);
        end
    end

    hudmp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (s2.cnt),
        .i_d0       (d0),
        .i_d1       (s2.r1),
        .i_pop      (o_valid && i_ready),
        .o_cnt      (q_cnt),
        .o_head     (head)
    );

    assign o_valid           = (q_cnt != '0);
    assign o_event_res       = head.event_res;
    assign o_icon_id         = head.icon_id;
    assign o_icon_value      = head.icon_value;
    assign o_main_updated    = head.main_updated;
    assign o_popup_shown     = head.popup_shown;
    assign o_main_centered   = head.main_centered;
    assign o_popup_centered  = head.popup_centered;
    assign o_pseudo_graphics = head.pseudo_graphics;
    assign o_main_length     = head.main_length;
    assign o_popup_length    = head.popup_length;
    assign o_read_byte       = head.read_byte;

endmodule

`default_nettype wire

// File: sv/hudmp_ram.sv
`default_nettype none

module hudmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/hudmp_parse.sv
`default_nettype none

module hudmp_parse import hudmp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_acc,
    input  logic         i_kind,
    input  logic [7:0]   i_byte_value,
    input  logic         i_last,
    input  logic         i_read_popup,
    input  logic [8:0]   i_read_index,
    input  logic [7:0]   i_main_rdata,
    input  logic [7:0]   i_pop_rdata,
    output logic         o_busy,
    output t_memreq      o_mem,
    output t_s2          o_s2
);

    typedef enum logic [8:0] {
        PH_HDR    = 9'b000000001,
        PH_TEXT   = 9'b000000010,
        PH_SEP    = 9'b000000100,
        PH_CNT2   = 9'b000001000,
        PH_ICON_A = 9'b000010000,
        PH_ICON_B = 9'b000100000,
        PH_ICON_C = 9'b001000000,
        PH_DONE   = 9'b010000000,
        PH_IGNORE = 9'b100000000
    } t_phase;

    typedef enum logic [4:0] {
        SQ_IDLE  = 5'b00001,
        SQ_FLUSH = 5'b00010,
        SQ_END   = 5'b00100,
        SQ_CMP   = 5'b01000,
        SQ_FIN   = 5'b10000
    } t_seq;

    t_phase           r_phase, n_phase;
    t_seq             r_seq, n_seq;
    logic [2:0]       r_pos, n_pos;
    logic [15:0]      r_dl, n_dl;
    logic [7:0]       r_type, n_type;
    logic [8:0]       r_rem, n_rem;
    logic [7:0]       r_f, n_f;
    logic [7:0]       r_s, n_s;
    logic [LEN_W-1:0] r_len0, n_len0;
    logic [LEN_W-1:0] r_len1, n_len1;
    logic [3:0]       r_flags, n_flags;
    logic             r_differs, n_differs;
    logic             r_bank, n_bank;
    logic [LEN_W-1:0] r_wp, n_wp;
    logic [LEN_W-1:0] r_pend, n_pend;
    logic [8:0]       r_raw, n_raw;
    logic             r_popup, n_popup;
    logic [7:0]       r_win [WIN_N];
    logic [7:0]       n_win [WIN_N];
    logic [3:0]       r_fill, n_fill;
    logic             r_last_pend, n_last_pend;
    logic [LEN_W-1:0] r_cmp_i, n_cmp_i;
    logic             r_cmp_v, n_cmp_v;
    t_s2              r_s2, n_s2;

    logic [7:0]       wn [WIN_N];
    logic [3:0]       fill1;
    logic             m_c, m_p, m_n;
    logic             st_en;
    logic [7:0]       st_byte;
    logic             tb_en, tb_popup;
    logic [8:0]       tb_count;
    logic             seq_start, do_last;
    logic             icon_push;
    logic [2:0]       icon_id_c;
    logic [1:0]       icon_val_c;
    logic             sum_push, sum_mu, sum_ps;
    logic [1:0]       need;
    logic [8:0]       tl2;
    t_res             res_icon, res_sum, res_rd;

    function automatic t_res make_res(input logic [1:0] ev, input logic [2:0] id,
                                      input logic [1:0] val, input logic mu,
                                      input logic ps, input logic [3:0] fl,
                                      input logic [LEN_W-1:0] l0,
                                      input logic [LEN_W-1:0] l1);
        t_res r;
        r.event_res       = ev;
        r.icon_id         = id;
        r.icon_value      = val;
        r.main_updated    = mu;
        r.popup_shown     = ps;
        r.main_centered   = fl[0];
        r.popup_centered  = fl[1];
        r.pseudo_graphics = fl[2];
        r.main_length     = 9'(l0);
        r.popup_length    = 9'(l1);
        r.read_byte       = 8'd0;
        return r;
    endfunction

    // window after appending the new byte, and tail matches
    always_comb begin
        for (int i = 0; i < WIN_N - 1; i++) begin
            wn[i] = r_win[i + 1];
        end
        wn[WIN_N - 1] = i_byte_value;
        fill1 = r_fill + 4'd1;
        m_c = (fill1 >= 4'(CTR_N));
        for (int i = 0; i < CTR_N; i++) begin
            if (wn[WIN_N - CTR_N + i] != SEQ_CENTER[i]) m_c = 1'b0;
        end
        m_p = (fill1 == 4'(WIN_N));
        m_n = (fill1 == 4'(WIN_N));
        for (int i = 0; i < WIN_N; i++) begin
            if (wn[i] != SEQ_PSEUDO[i]) m_p = 1'b0;
            if (wn[i] != SEQ_NORMAL[i]) m_n = 1'b0;
        end
    end

    // parse control, window update and store traffic
    always_comb begin
        n_phase     = r_phase;
        n_seq       = r_seq;
        n_pos       = r_pos;
        n_dl        = r_dl;
        n_type      = r_type;
        n_rem       = r_rem;
        n_f         = r_f;
        n_s         = r_s;
        n_len0      = r_len0;
        n_len1      = r_len1;
        n_flags     = r_flags;
        n_differs   = r_differs;
        n_bank      = r_bank;
        n_wp        = r_wp;
        n_pend      = r_pend;
        n_raw       = r_raw;
        n_popup     = r_popup;
        n_win       = r_win;
        n_fill      = r_fill;
        n_last_pend = r_last_pend;
        n_cmp_i     = r_cmp_i;
        n_cmp_v     = r_cmp_v;
        st_en       = 1'b0;
        st_byte     = wn[0];
        tb_en       = 1'b0;
        tb_popup    = 1'b0;
        tb_count    = 9'd0;
        seq_start   = 1'b0;
        do_last     = 1'b0;
        icon_push   = 1'b0;
        icon_id_c   = ID_ALL_OFF;
        icon_val_c  = 2'd0;
        sum_push    = 1'b0;
        sum_mu      = 1'b0;
        sum_ps      = 1'b0;
        need        = 2'd0;
        tl2         = {i_byte_value, 1'b0};
        o_mem.main_raddr = {r_bank, i_read_index[TEXT_AW-1:0]};
        o_mem.pop_raddr  = i_read_index[TEXT_AW-1:0];

        unique case (r_seq)
            SQ_IDLE: begin
                if (i_acc && !i_kind) begin
                    unique case (r_phase)
                        PH_HDR: begin
                            n_pos = (r_pos == 3'd7) ? r_pos : r_pos + 3'd1;
                            case (r_pos)
                                3'd0: if (i_byte_value != HDR_LEAD) n_phase = PH_IGNORE;
                                3'd1: if (i_byte_value != HDR_ID) n_phase = PH_IGNORE;
                                3'd2: begin
                                    n_type = i_byte_value;
                                    if (i_byte_value != TYPE_MAIN && i_byte_value != TYPE_POPUP
                                        && i_byte_value != TYPE_ICON) n_phase = PH_IGNORE;
                                end
                                3'd3: n_dl = {i_byte_value, 8'h00};
                                3'd4: begin
                                    n_dl = {r_dl[15:8], i_byte_value};
                                    if ({r_dl[15:8], i_byte_value} <
                                        ((r_type == TYPE_MAIN) ? 16'd5 :
                                         (r_type == TYPE_POPUP) ? 16'd7 : 16'd3))
                                        n_phase = PH_IGNORE;
                                end
                                3'd5: begin
                                    if (i_byte_value != SUB_START) begin
                                        n_phase = PH_IGNORE;
                                    end else if (r_type == TYPE_ICON) begin
                                        n_dl      = r_dl - 16'd1;
                                        icon_push = 1'b1;
                                        n_phase   = PH_ICON_A;
                                    end
                                end
                                3'd6: if (i_byte_value != SUB_MAIN) n_phase = PH_IGNORE;
                                default: begin
                                    n_raw = tl2;
                                    if (r_type == TYPE_MAIN &&
                                        17'(r_dl) < 17'(tl2) + 17'd3) begin
                                        n_phase = PH_IGNORE;
                                    end else begin
                                        tb_en    = 1'b1;
                                        tb_count = tl2;
                                    end
                                end
                            endcase
                        end
                        PH_TEXT: begin
                            n_win = wn;
                            if (m_c) begin
                                n_fill = fill1 - 4'(CTR_N);
                                for (int i = CTR_N; i < WIN_N; i++) begin
                                    n_win[i] = wn[i - CTR_N];
                                end
                                if (r_popup) n_flags[1] = 1'b1;
                                else n_flags[0] = 1'b1;
                            end else if (m_p) begin
                                n_fill = 4'd0;
                                if (!r_flags[3]) n_flags[2] = 1'b1;
                            end else if (m_n) begin
                                n_fill     = 4'd0;
                                n_flags[2] = 1'b0;
                                n_flags[3] = 1'b1;
                            end else if (fill1 == 4'(WIN_N)) begin
                                st_en   = 1'b1;
                                st_byte = wn[0];
                                n_fill  = 4'(WIN_N - 1);
                            end else begin
                                n_fill = fill1;
                            end
                            n_rem = r_rem - 9'd1;
                            if (r_rem == 9'd1) seq_start = 1'b1;
                        end
                        PH_SEP: n_phase = (i_byte_value == SUB_POPUP) ? PH_CNT2 : PH_IGNORE;
                        PH_CNT2: begin
                            if (17'(r_dl) < 17'(r_raw) + 17'(tl2) + 17'd5) begin
                                n_phase = PH_IGNORE;
                            end else begin
                                tb_en    = 1'b1;
                                tb_popup = 1'b1;
                                tb_count = tl2;
                            end
                        end
                        PH_ICON_A: begin
                            case (i_byte_value)
                                8'h01, 8'h02, 8'h03: need = 2'd3;
                                REC_MP3, REC_RDM:    need = 2'd2;
                                default:             need = 2'd0;
                            endcase
                            if (need == 2'd0 || r_dl < 16'(need)) begin
                                n_phase = PH_IGNORE;
                            end else begin
                                n_f     = i_byte_value;
                                n_dl    = r_dl - 16'd1;
                                n_phase = PH_ICON_B;
                            end
                        end
                        PH_ICON_B: begin
                            if (r_f == REC_MP3 || r_f == REC_RDM) begin
                                icon_push  = 1'b1;
                                icon_id_c  = (r_f == REC_MP3) ? ID_MP3 : ID_RDM;
                                icon_val_c = {1'b0, i_byte_value == 8'd1};
                                n_dl       = r_dl - 16'd1;
                                n_phase    = PH_ICON_A;
                            end else if ((r_f == 8'd1 && (i_byte_value == 8'd1 ||
                                                          i_byte_value == 8'd2)) ||
                                         (r_f == 8'd2 && i_byte_value == 8'd1) ||
                                         (r_f == 8'd3 && i_byte_value == 8'h80)) begin
                                n_s     = i_byte_value;
                                n_dl    = r_dl - 16'd1;
                                n_phase = PH_ICON_C;
                            end else begin
                                n_phase = PH_IGNORE;
                            end
                        end
                        PH_ICON_C: begin
                            icon_push = 1'b1;
                            if (r_f == 8'd1 && r_s == 8'd1) begin
                                icon_id_c  = ID_AS;
                                icon_val_c = {1'b0, i_byte_value == 8'd1};
                            end else if (r_f == 8'd1) begin
                                icon_id_c  = ID_RDS;
                                icon_val_c = {1'b0, i_byte_value == 8'd2};
                            end else if (r_f == 8'd2) begin
                                icon_id_c  = ID_CDIN;
                                icon_val_c = {1'b0, i_byte_value == 8'd1};
                            end else begin
                                icon_id_c  = ID_TP;
                                icon_val_c = (i_byte_value >= 8'd1 && i_byte_value <= 8'd3) ?
                                             i_byte_value[1:0] : 2'd0;
                            end
                            n_dl    = r_dl - 16'd1;
                            n_phase = PH_ICON_A;
                        end
                        PH_DONE, PH_IGNORE: begin
                        end
                        default: n_phase = PH_IGNORE;
                    endcase
                end
            end
            SQ_FLUSH: begin
                st_en   = 1'b1;
                st_byte = r_win[4'(WIN_N) - r_fill];
                n_fill  = r_fill - 4'd1;
                if (r_fill == 4'd1) n_seq = SQ_END;
            end
            SQ_END: begin
                if (r_popup) begin
                    n_len1    = r_wp;
                    n_differs = (r_wp != r_pend);
                    n_phase   = PH_DONE;
                    n_cmp_i   = '0;
                    n_cmp_v   = 1'b0;
                    n_seq     = (r_wp == r_pend && r_pend != '0) ? SQ_CMP : SQ_FIN;
                end else begin
                    n_pend  = r_wp;
                    n_phase = (r_type == TYPE_POPUP) ? PH_SEP : PH_DONE;
                    n_seq   = SQ_FIN;
                end
            end
            SQ_CMP: begin
                o_mem.main_raddr = {~r_bank, r_cmp_i[TEXT_AW-1:0]};
                o_mem.pop_raddr  = r_cmp_i[TEXT_AW-1:0];
                if (r_cmp_i < r_pend) begin
                    n_cmp_i = r_cmp_i + LEN_W'(1);
                    n_cmp_v = 1'b1;
                end else begin
                    n_cmp_v = 1'b0;
                end
                if (r_cmp_v && i_main_rdata != i_pop_rdata) n_differs = 1'b1;
                if (r_cmp_i == r_pend && !r_cmp_v) n_seq = SQ_FIN;
            end
            SQ_FIN: begin
                do_last     = r_last_pend;
                n_last_pend = 1'b0;
                n_seq       = SQ_IDLE;
            end
            default: n_seq = SQ_IDLE;
        endcase

        // start of a text section
        if (tb_en) begin
            n_phase  = PH_TEXT;
            n_popup  = tb_popup;
            n_wp     = '0;
            n_fill   = 4'd0;
            n_rem    = tb_count;
            if (tb_popup) begin
                n_flags[1] = 1'b0;
                n_len1     = '0;
            end else begin
                n_flags[0] = 1'b0;
            end
            n_flags[3:2] = 2'b00;
            if (tb_count == 9'd0) seq_start = 1'b1;
        end

        // end of a text section hands over to the flush sequencer
        if (seq_start) begin
            n_seq = (n_fill != 4'd0) ? SQ_FLUSH : SQ_END;
        end

        // store one text byte
        o_mem.main_we    = 1'b0;
        o_mem.pop_we     = 1'b0;
        o_mem.wdata      = st_byte;
        o_mem.main_waddr = {~r_bank, r_wp[TEXT_AW-1:0]};
        o_mem.pop_waddr  = r_wp[TEXT_AW-1:0];
        if (st_en && r_wp < LEN_W'(TEXT_DEPTH)) begin
            o_mem.main_we = !r_popup;
            o_mem.pop_we  = r_popup;
            n_wp          = r_wp + LEN_W'(1);
        end

        // message end: commit and summary
        if (r_seq == SQ_IDLE && i_acc && !i_kind && i_last) begin
            if (seq_start) n_last_pend = 1'b1;
            else do_last = 1'b1;
        end
        if (do_last) begin
            sum_push = 1'b1;
            sum_mu   = (n_phase == PH_DONE) && (n_type == TYPE_MAIN || n_type == TYPE_POPUP);
            if (sum_mu) begin
                n_bank = ~r_bank;
                n_len0 = n_pend;
                sum_ps = (n_type == TYPE_POPUP) && n_differs;
            end
            n_pos   = 3'd0;
            n_phase = PH_HDR;
            n_fill  = 4'd0;
            n_rem   = 9'd0;
        end

        // results for the next stage
        res_icon = make_res(EV_ICON, icon_id_c, icon_val_c, 1'b0, 1'b0, n_flags,
                            n_len0, n_len1);
        res_sum  = make_res(EV_SUMMARY, ID_ALL_OFF, 2'd0, sum_mu, sum_ps, n_flags,
                            n_len0, n_len1);
        res_rd   = make_res(EV_READ, ID_ALL_OFF, 2'd0, 1'b0, 1'b0, r_flags,
                            r_len0, r_len1);
        n_s2          = '0;
        n_s2.rd_popup = i_read_popup;
        n_s2.rd_zero  = i_read_popup ? !(10'(i_read_index) < 10'(r_len1)) :
                                       !(10'(i_read_index) < 10'(r_len0));
        if (r_seq == SQ_IDLE && i_acc && i_kind) begin
            n_s2.cnt = 2'd1;
            n_s2.rd  = 1'b1;
            n_s2.r0  = res_rd;
        end else if (icon_push && sum_push) begin
            n_s2.cnt = 2'd2;
            n_s2.r0  = res_icon;
            n_s2.r1  = res_sum;
        end else if (icon_push) begin
            n_s2.cnt = 2'd1;
            n_s2.r0  = res_icon;
        end else if (sum_push) begin
            n_s2.cnt = 2'd1;
            n_s2.r0  = res_sum;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_seq       <= SQ_IDLE;
            r_pos       <= 3'd0;
            r_dl        <= 16'd0;
            r_type      <= 8'd0;
            r_rem       <= 9'd0;
            r_f         <= 8'd0;
            r_s         <= 8'd0;
            r_len0      <= '0;
            r_len1      <= '0;
            r_flags     <= 4'd0;
            r_differs   <= 1'b0;
            r_bank      <= 1'b0;
            r_wp        <= '0;
            r_pend      <= '0;
            r_raw       <= 9'd0;
            r_popup     <= 1'b0;
            r_fill      <= 4'd0;
            r_last_pend <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_s2        <= '0;
        end else begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_pos       <= n_pos;
            r_dl        <= n_dl;
            r_type      <= n_type;
            r_rem       <= n_rem;
            r_f         <= n_f;
            r_s         <= n_s;
            r_len0      <= n_len0;
            r_len1      <= n_len1;
            r_flags     <= n_flags;
            r_differs   <= n_differs;
            r_bank      <= n_bank;
            r_wp        <= n_wp;
            r_pend      <= n_pend;
            r_raw       <= n_raw;
            r_popup     <= n_popup;
            r_fill      <= n_fill;
            r_last_pend <= n_last_pend;
            r_cmp_v     <= n_cmp_v;
            r_s2        <= n_s2;
        end
    end

    // window bytes and compare index
    always_ff @(posedge i_clk) begin
        r_win   <= n_win;
        r_cmp_i <= n_cmp_i;
    end

    assign o_busy = (r_seq != SQ_IDLE);
    assign o_s2   = r_s2;

endmodule

`default_nettype wire

// File: sv/hudmp_outq.sv
`default_nettype none

module hudmp_outq import hudmp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_cnt,
    input  t_res               i_d0,
    input  t_res               i_d1,
    input  logic               i_pop,
    output logic [OUTQ_CW-1:0] o_cnt,
    output t_res               o_head
);

    t_res               r_q [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wr, n_wr;
    logic [OUTQ_AW-1:0] r_rd, n_rd;
    logic [OUTQ_CW-1:0] r_cnt, n_cnt;

    // pointer and fill update, up to two pushes and one pop
    always_comb begin
        n_wr  = r_wr + OUTQ_AW'(i_push_cnt);
        n_rd  = i_pop ? r_rd + OUTQ_AW'(1) : r_rd;
        n_cnt = r_cnt + OUTQ_CW'(i_push_cnt) - OUTQ_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_q[r_wr] <= i_d0;
        if (i_push_cnt == 2'd2) r_q[r_wr + OUTQ_AW'(1)] <= i_d1;
    end

    assign o_cnt  = r_cnt;
    assign o_head = r_q[r_rd];

endmodule

`default_nettype wire

// File: sv/hudmp_chk.sv
`default_nettype none

`include "head_unit_display_message_parser_macros.svh"

module hudmp_chk import hudmp_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_kind,
    input logic [7:0] i_byte_value,
    input logic       i_last,
    input logic       i_read_popup,
    input logic [8:0] i_read_index,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_event_res,
    input logic [2:0] o_icon_id,
    input logic [1:0] o_icon_value,
    input logic       o_main_updated,
    input logic       o_popup_shown,
    input logic       o_main_centered,
    input logic       o_popup_centered,
    input logic       o_pseudo_graphics,
    input logic [8:0] o_main_length,
    input logic [8:0] o_popup_length,
    input logic [7:0] o_read_byte
);

    // stalled result holds
    `HUDMP_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_event_res) && $stable(o_read_byte) && $stable(o_icon_id))

    // summaries and reads carry no icon
    `HUDMP_ASSERT_NOW(a_no_icon, o_valid && o_event_res != EV_ICON, o_icon_id == ID_ALL_OFF && o_icon_value == 2'd0)

    // popup shown only with a committed main text in a summary
    `HUDMP_ASSERT_NOW(a_popup_commit, o_valid && o_popup_shown, o_main_updated && o_event_res == EV_SUMMARY)

    // only the traffic icon has more than on and off
    `HUDMP_ASSERT_NOW(a_icon_value, o_valid && o_event_res == EV_ICON && o_icon_id != ID_TP, o_icon_value[1] == 1'b0)

endmodule

bind head_unit_display_message_parser hudmp_chk u_chk (.*);

`default_nettype wire
